[design/ssc_pkg.sv]
// Stepper stroke controller: shared widths, register indexes, reset values,
// the full-step phase table and the result item type.
// No dependencies.
package ssc_pkg;

    localparam int SSC_POS_W    = 12;
    localparam int SSC_STEPS_W  = 16;
    localparam int SSC_TIME_W   = 24;
    localparam int SSC_COIL_W   = 4;
    localparam int SSC_CFG_IDX_W = 3;
    localparam int SSC_CFG_DAT_W = 24;

    // register indexes on the configuration channel
    localparam logic [SSC_CFG_IDX_W-1:0] REG_STEP_INTERVAL   = 3'd0;
    localparam logic [SSC_CFG_IDX_W-1:0] REG_TORQUE_INTERVAL = 3'd1;
    localparam logic [SSC_CFG_IDX_W-1:0] REG_STROKE_STEPS    = 3'd2;
    localparam logic [SSC_CFG_IDX_W-1:0] REG_REVERSED        = 3'd3;
    localparam logic [SSC_CFG_IDX_W-1:0] REG_STEPS_PER_REV   = 3'd4;

    // item opcodes
    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_SET_READY = 1'b1;

    localparam logic [SSC_TIME_W-1:0]  RST_STEP_INTERVAL   = 24'd300;
    localparam logic [SSC_TIME_W-1:0]  RST_TORQUE_INTERVAL = 24'd1800;
    localparam logic [SSC_STEPS_W-1:0] RST_STROKE_STEPS    = 16'd700;
    localparam logic [SSC_POS_W-1:0]   RST_STEPS_PER_REV   = 12'd200;

    localparam logic [SSC_TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SSC_COIL_W-1:0] COILS_OFF = '0;

    typedef struct packed {
        logic                  active;
        logic                  running;
        logic                  armed;
        logic                  last_commanded;
        logic [SSC_POS_W-1:0]  position;
        logic [SSC_COIL_W-1:0] coil_pattern;
        logic                  low_side_enable;
        logic                  stroke_done;
    } t_result;

    // bit3 A+, bit2 A-, bit1 B+, bit0 B-
    function automatic logic [SSC_COIL_W-1:0] phase_pattern(input logic [1:0] ph);
        logic [SSC_COIL_W-1:0] pat;
        case (ph)
            2'd0:    pat = 4'hA;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'h5;
            2'd3:    pat = 4'h9;
            default: pat = COILS_OFF;
        endcase
        return pat;
    endfunction

endpackage

[design/ssc_if.sv]
// Stepper stroke controller: valid/ready channel interfaces for command
// items, result items and register writes. Depends on ssc_pkg.
interface ssc_cmd_if;
    import ssc_pkg::*;
    logic valid;
    logic ready;
    logic op;
    logic direction;
    modport source (output valid, op, direction, input ready);
    modport sink   (input valid, op, direction, output ready);
endinterface

interface ssc_res_if;
    import ssc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  active;
    logic                  running;
    logic                  armed;
    logic                  last_commanded;
    logic [SSC_POS_W-1:0]  position;
    logic [SSC_COIL_W-1:0] coil_pattern;
    logic                  low_side_enable;
    logic                  stroke_done;
    modport source (output valid, active, running, armed, last_commanded, position,
                    coil_pattern, low_side_enable, stroke_done, input ready);
    modport sink   (input valid, active, running, armed, last_commanded, position,
                    coil_pattern, low_side_enable, stroke_done, output ready);
endinterface

interface ssc_cfg_if;
    import ssc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [SSC_CFG_IDX_W-1:0] index;
    logic [SSC_CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/stepper_stroke_controller_core.sv]
// Stepper stroke controller top level: input register, stroke state update
// and result register. Depends on ssc_pkg and the interfaces in ssc_if.
//
// Full-step bipolar stepper stroke controller. Each command item is a one
// microsecond tick or a set_ready; every item gives exactly one result item.
// The block takes one item per clock cycle while the result sink is not stalled:
// an item sits in the input register while the stroke state and result are
// computed, and its result is then offered from the result register. Ready
// drops only when the result register is held by a stalled sink and the input
// register is full. Register writes are always accepted and must be made while
// no item is in flight.
module stepper_stroke_controller_core (
    input  logic i_clk,
    input  logic i_rst_n,
    ssc_cmd_if.sink   i_cmd,
    ssc_cfg_if.sink   i_cfg,
    ssc_res_if.source o_res
);
    import ssc_pkg::*;

    // configuration
    logic [SSC_TIME_W-1:0]  r_step_interval;
    logic [SSC_TIME_W-1:0]  r_torque_interval;
    logic [SSC_STEPS_W-1:0] r_stroke_steps;
    logic                   r_reversed;
    logic [SSC_POS_W-1:0]   r_steps_per_rev;

    // pipeline
    logic    r_s1_valid;
    logic    r_s1_op;
    logic    r_s1_dir;
    logic    r_out_valid;
    t_result r_res;
    logic    s1_move;
    logic    cmd_accept;

    // stroke state
    logic                   r_armed,    n_armed;
    logic                   r_running,  n_running;
    logic                   r_next_dir, n_next_dir;
    logic                   r_stroke_dir, n_stroke_dir;
    logic                   r_last_cmd, n_last_cmd;
    logic [SSC_POS_W-1:0]   r_pos,      n_pos;
    logic [SSC_STEPS_W-1:0] r_steps,    n_steps;
    logic [SSC_TIME_W-1:0]  r_elapsed,  n_elapsed;
    logic [SSC_COIL_W-1:0]  r_coil,     n_coil;
    logic                   r_low_side, n_low_side;
    logic                   res_active;
    logic                   res_done;

    logic [SSC_POS_W:0]     pos_up_sum;
    logic [SSC_POS_W-1:0]   pos_up;
    logic [SSC_POS_W-1:0]   pos_down;

    assign s1_move     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_s1_valid || s1_move;
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    // position is not touched before a step, so both neighbours come from r_pos
    assign pos_up_sum = {1'b0, r_pos} + {{SSC_POS_W{1'b0}}, 1'b1};
    assign pos_up     = (pos_up_sum >= {1'b0, r_steps_per_rev}) ? '0
                                                                : pos_up_sum[SSC_POS_W-1:0];
    assign pos_down   = (r_pos == '0 || r_pos >= r_steps_per_rev)
                        ? r_steps_per_rev - {{(SSC_POS_W-1){1'b0}}, 1'b1}
                        : r_pos - {{(SSC_POS_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_armed      = r_armed;
        n_running    = r_running;
        n_next_dir   = r_next_dir;
        n_stroke_dir = r_stroke_dir;
        n_last_cmd   = r_last_cmd;
        n_pos        = r_pos;
        n_steps      = r_steps;
        n_elapsed    = r_elapsed;
        n_coil       = r_coil;
        n_low_side   = r_low_side;
        res_active   = 1'b0;
        res_done     = 1'b0;
        if (r_s1_op == OP_SET_READY) begin
            n_last_cmd = r_s1_dir;
            n_next_dir = r_s1_dir ^ r_reversed;
            n_armed    = 1'b1;
        end else if (r_armed || r_running) begin
            res_active = 1'b1;
            if (r_steps == '0) begin
                n_low_side   = 1'b1;
                n_stroke_dir = r_next_dir;
                n_steps      = r_stroke_steps;
                n_armed      = 1'b0;
                n_running    = 1'b1;
                n_elapsed    = '0;
            end else if (r_elapsed != TIME_MAX) begin
                n_elapsed = r_elapsed + {{(SSC_TIME_W-1){1'b0}}, 1'b1};
            end
            if (n_elapsed >= r_torque_interval) begin
                n_coil = COILS_OFF;
            end
            if (n_elapsed >= r_step_interval) begin
                n_elapsed = '0;
                n_pos     = n_stroke_dir ? pos_up : pos_down;
                n_steps   = n_steps - {{(SSC_STEPS_W-1){1'b0}}, 1'b1};
                if (n_steps == '0) begin
                    n_coil     = COILS_OFF;
                    n_low_side = 1'b0;
                    n_running  = 1'b0;
                    res_done   = 1'b1;
                end else begin
                    n_coil = phase_pattern(n_pos[1:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval   <= RST_STEP_INTERVAL;
            r_torque_interval <= RST_TORQUE_INTERVAL;
            r_stroke_steps    <= RST_STROKE_STEPS;
            r_reversed        <= 1'b0;
            r_steps_per_rev   <= RST_STEPS_PER_REV;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_STEP_INTERVAL:   r_step_interval   <= i_cfg.data[SSC_TIME_W-1:0];
                REG_TORQUE_INTERVAL: r_torque_interval <= i_cfg.data[SSC_TIME_W-1:0];
                REG_STROKE_STEPS:    r_stroke_steps    <= i_cfg.data[SSC_STEPS_W-1:0];
                REG_REVERSED:        r_reversed        <= i_cfg.data[0];
                REG_STEPS_PER_REV:   r_steps_per_rev   <= i_cfg.data[SSC_POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_accept) begin
            r_s1_op  <= i_cmd.op;
            r_s1_dir <= i_cmd.direction;
        end
        if (s1_move) begin
            r_res.active          <= res_active;
            r_res.running         <= n_running;
            r_res.armed           <= n_armed;
            r_res.last_commanded  <= n_last_cmd;
            r_res.position        <= n_pos;
            r_res.coil_pattern    <= n_coil;
            r_res.low_side_enable <= n_low_side;
            r_res.stroke_done     <= res_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_running    <= 1'b0;
            r_next_dir   <= 1'b0;
            r_stroke_dir <= 1'b0;
            r_last_cmd   <= 1'b0;
            r_pos        <= '0;
            r_steps      <= '0;
            r_elapsed    <= '0;
            r_coil       <= COILS_OFF;
            r_low_side   <= 1'b0;
        end else if (s1_move) begin
            r_armed      <= n_armed;
            r_running    <= n_running;
            r_next_dir   <= n_next_dir;
            r_stroke_dir <= n_stroke_dir;
            r_last_cmd   <= n_last_cmd;
            r_pos        <= n_pos;
            r_steps      <= n_steps;
            r_elapsed    <= n_elapsed;
            r_coil       <= n_coil;
            r_low_side   <= n_low_side;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.active          = r_res.active;
    assign o_res.running         = r_res.running;
    assign o_res.armed           = r_res.armed;
    assign o_res.last_commanded  = r_res.last_commanded;
    assign o_res.position        = r_res.position;
    assign o_res.coil_pattern    = r_res.coil_pattern;
    assign o_res.low_side_enable = r_res.low_side_enable;
    assign o_res.stroke_done     = r_res.stroke_done;

    // no stroke in progress means no steps left
    a_idle_no_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> r_steps == '0)
        else $error("steps remaining while not running");

    // energised coils need the low side driven
    a_coil_low_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_coil != COILS_OFF |-> r_low_side)
        else $error("coils driven with low side tri-stated");

    // a finishing item reports the stroke stopped with coils released
    a_done_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.stroke_done |->
            !r_res.running && r_res.coil_pattern == COILS_OFF && !r_res.low_side_enable)
        else $error("stroke done with drive still on");

    // a held item in the input register stays until the result stage frees
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && $stable(r_s1_op))
        else $error("input register item lost under stall");

endmodule
